### src/fixed_point_alu_defines.svh
// Assertion macros shared by the fixed-point ALU checkers.
// Expect clk and rst_n in the scope of every use.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define FPA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fpa_pkg.sv
`timescale 1ns / 1ps
// Package for the fixed-point ALU: opcodes, port layout, control struct
// and the saturation helper shared by the multiply and divide paths.
package fpa_pkg;

  localparam int unsigned FRAC_W_DEF     = 8;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 4;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam int unsigned OUT_LESS_BIT    = 32;
  localparam int unsigned OUT_EQUAL_BIT   = 33;
  localparam int unsigned OUT_GREATER_BIT = 34;
  localparam int unsigned OUT_OVF_BIT     = 35;
  localparam int unsigned OUT_DZ_BIT      = 36;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_CMP      = 4'd4,
    OP_MIN      = 4'd5,
    OP_MAX      = 4'd6,
    OP_INC      = 4'd7,
    OP_DEC      = 4'd8,
    OP_TO_INT   = 4'd9,
    OP_FROM_INT = 4'd10
  } op_t;

  typedef struct packed {
    logic is_div;
    logic neg;
    logic lt;
    logic eq;
    logic gt;
    logic ovf;
    logic dz;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  // Apply sign to a magnitude, clamp to a ww-bit word, sign-extend to DATA_W
  function automatic sat_t saturate(input logic neg, input logic [63:0] q,
                                    input int unsigned ww);
    logic [63:0] wmax;
    logic [63:0] q_neg;
    sat_t        s;
    wmax  = (64'd1 << (ww - 1)) - 64'd1;
    q_neg = 64'd0 - q;
    s.ovf = 1'b0;
    if (neg) begin
      if (q > wmax + 64'd1) begin
        s.ovf = 1'b1;
        s.val = DATA_W'(~wmax);
      end else begin
        s.val = DATA_W'(q_neg);
      end
    end else if (q > wmax) begin
      s.ovf = 1'b1;
      s.val = DATA_W'(wmax);
    end else begin
      s.val = DATA_W'(q);
    end
    return s;
  endfunction

endpackage

### src/fpa_prep.sv
`timescale 1ns / 1ps
// Front stages of the fixed-point ALU: operand decode, simple ops, the
// multiplier and its rounding. Depends on fpa_pkg.
module fpa_prep #(
  parameter int unsigned WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF,
  parameter int unsigned FRAC_W     = fpa_pkg::FRAC_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fpa_pkg::OP_W-1:0]     op,
  input  logic [fpa_pkg::DATA_W-1:0]   a,
  input  logic [fpa_pkg::DATA_W-1:0]   b,
  output logic                         valid_o,
  output fpa_pkg::ctl_t                ctl_o,
  output logic [fpa_pkg::DATA_W-1:0]   res_o,
  output logic [WORD_WIDTH-1:0]        d_o,
  output logic [WORD_WIDTH+FRAC_W-1:0] nq_o
);

  localparam int unsigned QW = WORD_WIDTH + FRAC_W;
  localparam int unsigned PW = 2 * WORD_WIDTH;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_W - 1);

  logic [WORD_WIDTH-1:0]        au, bu;
  logic signed [WORD_WIDTH-1:0] a_s, b_s;
  logic [WORD_WIDTH-1:0]        mag_a, mag_b;
  logic [PW-1:0]                prod_c;
  logic [WORD_WIDTH-1:0]        res_u;
  fpa_pkg::ctl_t                ctl_c;
  logic                         mul_c;

  logic                         va_r;
  fpa_pkg::ctl_t                ctl_a_r;
  logic                         mul_a_r;
  logic [fpa_pkg::DATA_W-1:0]   res_a_r;
  logic [PW-1:0]                prod_a_r;
  logic [WORD_WIDTH-1:0]        maga_r, magb_r;

  logic [PW:0]                  psum;
  logic [63:0]                  q_mul;
  fpa_pkg::sat_t                sat_mul;
  fpa_pkg::ctl_t                ctl_b_nxt;

  logic                         vb_r;
  fpa_pkg::ctl_t                ctl_b_r;
  logic [fpa_pkg::DATA_W-1:0]   res_b_r;
  logic [WORD_WIDTH-1:0]        d_r;
  logic [QW-1:0]                nq_r;

  assign au    = a[WORD_WIDTH-1:0];
  assign bu    = b[WORD_WIDTH-1:0];
  assign a_s   = $signed(au);
  assign b_s   = $signed(bu);
  assign mag_a = au[WORD_WIDTH-1] ? (~au + WORD_WIDTH'(1)) : au;
  assign mag_b = bu[WORD_WIDTH-1] ? (~bu + WORD_WIDTH'(1)) : bu;
  assign prod_c = PW'(mag_a) * PW'(mag_b);

  always_comb begin
    res_u      = '0;
    mul_c      = 1'b0;
    ctl_c      = '0;
    ctl_c.neg  = au[WORD_WIDTH-1] ^ bu[WORD_WIDTH-1];
    case (op)
      fpa_pkg::OP_ADD:      res_u = au + bu;
      fpa_pkg::OP_SUB:      res_u = au - bu;
      fpa_pkg::OP_MUL:      mul_c = 1'b1;
      fpa_pkg::OP_DIV: begin
        ctl_c.is_div = 1'b1;
        ctl_c.dz     = (bu == '0);
      end
      fpa_pkg::OP_CMP: begin
        ctl_c.lt = (a_s < b_s);
        ctl_c.eq = (a_s == b_s);
        ctl_c.gt = (a_s > b_s);
      end
      fpa_pkg::OP_MIN:      res_u = (a_s <= b_s) ? au : bu;
      fpa_pkg::OP_MAX:      res_u = (a_s >= b_s) ? au : bu;
      fpa_pkg::OP_INC:      res_u = au + WORD_WIDTH'(1);
      fpa_pkg::OP_DEC:      res_u = au - WORD_WIDTH'(1);
      fpa_pkg::OP_TO_INT:   res_u = a_s >>> FRAC_W;
      fpa_pkg::OP_FROM_INT: res_u = au << FRAC_W;
      default:              res_u = '0;
    endcase
  end

  assign in_ready = adv || !va_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (in_ready) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      ctl_a_r  <= ctl_c;
      mul_a_r  <= mul_c;
      res_a_r  <= fpa_pkg::DATA_W'($signed(res_u));
      prod_a_r <= prod_c;
      maga_r   <= mag_a;
      magb_r   <= mag_b;
    end
  end

  // Round half up on positive products, truncate on negative ones
  assign psum    = {1'b0, prod_a_r} + (ctl_a_r.neg ? '0 : HALF);
  assign q_mul   = 64'(psum >> FRAC_W);
  assign sat_mul = fpa_pkg::saturate(ctl_a_r.neg, q_mul, WORD_WIDTH);

  always_comb begin
    ctl_b_nxt     = ctl_a_r;
    ctl_b_nxt.ovf = mul_a_r && sat_mul.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_b_r <= ctl_b_nxt;
      res_b_r <= mul_a_r ? sat_mul.val : res_a_r;
      d_r     <= magb_r;
      nq_r    <= {maga_r, FRAC_W'(0)};
    end
  end

  assign valid_o = vb_r;
  assign ctl_o   = ctl_b_r;
  assign res_o   = res_b_r;
  assign d_o     = d_r;
  assign nq_o    = nq_r;

endmodule

### src/fpa_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: resolve one quotient bit and pass the item on.
// Depends on fpa_pkg.
module fpa_div_cell #(
  parameter int unsigned WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF,
  parameter int unsigned QW         = fpa_pkg::WORD_WIDTH_DEF + fpa_pkg::FRAC_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       valid_i,
  input  fpa_pkg::ctl_t              ctl_i,
  input  logic [fpa_pkg::DATA_W-1:0] res_i,
  input  logic [WORD_WIDTH-1:0]      d_i,
  input  logic [WORD_WIDTH-1:0]      rem_i,
  input  logic [QW-1:0]              nq_i,
  output logic                       valid_o,
  output fpa_pkg::ctl_t              ctl_o,
  output logic [fpa_pkg::DATA_W-1:0] res_o,
  output logic [WORD_WIDTH-1:0]      d_o,
  output logic [WORD_WIDTH-1:0]      rem_o,
  output logic [QW-1:0]              nq_o
);

  logic [WORD_WIDTH:0]        trial;
  logic [WORD_WIDTH:0]        diff;
  logic                       ge;
  logic [WORD_WIDTH-1:0]      rem_nxt;
  logic [QW-1:0]              nq_nxt;

  logic                       valid_r;
  fpa_pkg::ctl_t              ctl_r;
  logic [fpa_pkg::DATA_W-1:0] res_r;
  logic [WORD_WIDTH-1:0]      d_r;
  logic [WORD_WIDTH-1:0]      rem_r;
  logic [QW-1:0]              nq_r;

  assign trial   = {rem_i, nq_i[QW-1]};
  assign diff    = trial - {1'b0, d_i};
  assign ge      = (trial >= {1'b0, d_i});
  assign rem_nxt = ge ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
  assign nq_nxt  = {nq_i[QW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r <= ctl_i;
      res_r <= res_i;
      d_r   <= d_i;
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign res_o   = res_r;
  assign d_o     = d_r;
  assign rem_o   = rem_r;
  assign nq_o    = nq_r;

endmodule

### src/fpa_post.sv
`timescale 1ns / 1ps
// Output stage of the fixed-point ALU: divide rounding and saturation, flag
// packing and the output register. Depends on fpa_pkg.
module fpa_post #(
  parameter int unsigned WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF,
  parameter int unsigned QW         = fpa_pkg::WORD_WIDTH_DEF + fpa_pkg::FRAC_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            valid_i,
  input  fpa_pkg::ctl_t                   ctl_i,
  input  logic [fpa_pkg::DATA_W-1:0]      res_i,
  input  logic [WORD_WIDTH-1:0]           d_i,
  input  logic [WORD_WIDTH-1:0]           rem_i,
  input  logic [QW-1:0]                   nq_i,
  output logic                            out_valid,
  output logic [fpa_pkg::OUT_TDATA_W-1:0] out_data
);

  logic                            rnd;
  logic [63:0]                     q_div;
  fpa_pkg::sat_t                   sat_div;
  logic [fpa_pkg::DATA_W-1:0]      res_fin;
  logic                            ovf_fin;
  logic [fpa_pkg::OUT_TDATA_W-1:0] data_nxt;

  logic                            valid_r;
  logic [fpa_pkg::OUT_TDATA_W-1:0] data_r;

  // Round half up on positive quotients, truncate on negative ones
  assign rnd     = !ctl_i.neg && ({rem_i, 1'b0} >= {1'b0, d_i});
  assign q_div   = 64'(nq_i) + 64'(rnd);
  assign sat_div = fpa_pkg::saturate(ctl_i.neg, q_div, WORD_WIDTH);

  always_comb begin
    res_fin = res_i;
    ovf_fin = ctl_i.ovf;
    if (ctl_i.is_div) begin
      res_fin = ctl_i.dz ? '0 : sat_div.val;
      ovf_fin = !ctl_i.dz && sat_div.ovf;
    end
    data_nxt                              = '0;
    data_nxt[fpa_pkg::DATA_W-1:0]         = res_fin;
    data_nxt[fpa_pkg::OUT_LESS_BIT]       = ctl_i.lt;
    data_nxt[fpa_pkg::OUT_EQUAL_BIT]      = ctl_i.eq;
    data_nxt[fpa_pkg::OUT_GREATER_BIT]    = ctl_i.gt;
    data_nxt[fpa_pkg::OUT_OVF_BIT]        = ovf_fin;
    data_nxt[fpa_pkg::OUT_DZ_BIT]         = ctl_i.dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### src/fixed_point_alu.sv
`timescale 1ns / 1ps
// Fixed-point ALU top level: two front stages, a row of division cells and
// the output stage. Depends on fpa_pkg, fpa_prep, fpa_div_cell and fpa_post.
//
// Usage:
//   Input transfer on in_tvalid & in_tready: in_tuser carries the opcode,
//   in_tdata carries operand_a (low word) and operand_b (high word).
//   Output transfer on out_tvalid & out_tready: one result per input, in
//   order, with the result word and the compare, overflow and divide-by-zero
//   flags in out_tdata.
//   Every opcode takes the same path: the two front stages, the row of
//   division cells and the output register.
//   The division cells resolve one quotient bit each, so the row is
//   WORD_WIDTH + FRAC_W cells long.
//   Throughput is one transfer per cycle while out_tready is high.
//   When the receiver stalls, the output register and the whole row hold;
//   the first stage still takes a transfer while it is empty.
//   After reset all stages are empty and out_tvalid is low; there is no
//   clearing pass.
module fixed_point_alu #(
  parameter int unsigned FRAC_W     = fpa_pkg::FRAC_W_DEF,
  parameter int unsigned WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fpa_pkg::IN_TDATA_W-1:0]  in_tdata,   // operand_a, operand_b
  input  logic [fpa_pkg::OP_W-1:0]        in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // result, less, equal, greater, overflow, div_by_zero, zero padding
  output logic [fpa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned QW = WORD_WIDTH + FRAC_W;

  logic                       adv;
  logic                       v_w   [0:QW];
  fpa_pkg::ctl_t              ctl_w [0:QW];
  logic [fpa_pkg::DATA_W-1:0] res_w [0:QW];
  logic [WORD_WIDTH-1:0]      d_w   [0:QW];
  logic [WORD_WIDTH-1:0]      rem_w [0:QW];
  logic [QW-1:0]              nq_w  [0:QW];

  assign adv      = !out_tvalid || out_tready;
  assign rem_w[0] = '0;

  fpa_prep #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_W     (FRAC_W)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .op       (in_tuser),
    .a        (in_tdata[fpa_pkg::DATA_W-1:0]),
    .b        (in_tdata[fpa_pkg::IN_TDATA_W-1:fpa_pkg::DATA_W]),
    .valid_o  (v_w[0]),
    .ctl_o    (ctl_w[0]),
    .res_o    (res_w[0]),
    .d_o      (d_w[0]),
    .nq_o     (nq_w[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    fpa_div_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .QW         (QW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (v_w[i]),
      .ctl_i   (ctl_w[i]),
      .res_i   (res_w[i]),
      .d_i     (d_w[i]),
      .rem_i   (rem_w[i]),
      .nq_i    (nq_w[i]),
      .valid_o (v_w[i+1]),
      .ctl_o   (ctl_w[i+1]),
      .res_o   (res_w[i+1]),
      .d_o     (d_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .nq_o    (nq_w[i+1])
    );
  end

  fpa_post #(
    .WORD_WIDTH (WORD_WIDTH),
    .QW         (QW)
  ) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid_i   (v_w[QW]),
    .ctl_i     (ctl_w[QW]),
    .res_i     (res_w[QW]),
    .d_i       (d_w[QW]),
    .rem_i     (rem_w[QW]),
    .nq_i      (nq_w[QW]),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule

### src/fpa_checker.sv
`timescale 1ns / 1ps
// Port checker for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_alu_defines.svh.
`include "fixed_point_alu_defines.svh"

module fpa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fpa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [fpa_pkg::DATA_W-1:0] res_f;
  logic [2:0]                 cmp_f;
  logic                       ovf_f;
  logic                       dz_f;
  logic                       stall_f;

  assign res_f   = out_tdata[fpa_pkg::DATA_W-1:0];
  assign cmp_f   = out_tdata[fpa_pkg::OUT_GREATER_BIT:fpa_pkg::OUT_LESS_BIT];
  assign ovf_f   = out_tdata[fpa_pkg::OUT_OVF_BIT];
  assign dz_f    = out_tdata[fpa_pkg::OUT_DZ_BIT];
  assign stall_f = out_tvalid && !out_tready;

  `FPA_ASSERT_NEXT(a_out_hold, stall_f, out_tvalid && $stable(out_tdata), "output changed in stall")

  `FPA_ASSERT(a_cmp_onehot, out_tvalid, $countones(cmp_f) <= 1, "more than one compare flag set")

  `FPA_ASSERT(a_cmp_clean, out_tvalid && |cmp_f, res_f == '0 && !ovf_f && !dz_f, "compare not clean")

  `FPA_ASSERT(a_dz_zero, out_tvalid && dz_f, res_f == '0 && !ovf_f, "divide by zero not clean")

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
